FILE: sv/kcu_pkg.sv
// Package: payload types, command/status types and fixed widths for the unranking block.
`timescale 1ns / 1ps

package kcu_pkg;

  localparam int unsigned SYM_W  = 7;
  localparam int unsigned RANK_W = 30;
  localparam int unsigned PAT_W  = 64;

  typedef struct packed {
    logic [SYM_W-1:0]  dash_count;
    logic [SYM_W-1:0]  dot_count;
    logic [RANK_W-1:0] rank;
  } in_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [SYM_W-1:0] word_length;
    logic             error;
  } out_t;

  // Table read address source
  typedef enum logic [1:0] {
    RD_FILL,
    RD_CHECK,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    fill;
    logic    step;
    logic    fin_ok;
    logic    fin_err;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic too_long;
    logic rank_big;
    logic n_zero;
    logic walk_last;
  } stat_t;

endpackage

FILE: sv/kcu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module kcu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/kcu_ctrl.sv
// Controller: table fill after reset, length and rank check and one-symbol-per-cycle walk.
`timescale 1ns / 1ps

module kcu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  kcu_pkg::stat_t stat_i,
  output kcu_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_CHK_RD,
    S_CHK,
    S_WALK
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;

  always_comb begin
    state_d       = state_q;
    busy_d        = busy_q;
    done_d        = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_sel  = kcu_pkg::RD_NEXT;
    case (state_q)
      S_FILL: begin
        cmd_o.fill   = 1'b1;
        cmd_o.rd_sel = kcu_pkg::RD_FILL;
        if (stat_i.fill_last) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK_RD;
          busy_d     = 1'b1;
        end
      end
      S_CHK_RD: begin
        cmd_o.rd_sel = kcu_pkg::RD_CHECK;
        if (stat_i.too_long) begin
          cmd_o.fin_err = 1'b1;
          state_d       = S_IDLE;
          busy_d        = 1'b0;
          done_d        = 1'b1;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.rank_big) begin
          cmd_o.fin_err = 1'b1;
          state_d       = S_IDLE;
          busy_d        = 1'b0;
          done_d        = 1'b1;
        end else if (stat_i.n_zero) begin
          cmd_o.fin_ok = 1'b1;
          state_d      = S_IDLE;
          busy_d       = 1'b0;
          done_d       = 1'b1;
        end else begin
          // first lookup: words of the remaining length that open with a dash
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (stat_i.walk_last) begin
          cmd_o.fin_ok = 1'b1;
          state_d      = S_IDLE;
          busy_d       = 1'b0;
          done_d       = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

FILE: sv/kcu_dp.sv
// Datapath: binomial table RAM with its fill logic, rank/count registers and result word.
`timescale 1ns / 1ps

module kcu_dp #(
  parameter int unsigned MAX_SYMBOLS = 64,
  parameter int unsigned RANK_BITS   = 30
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kcu_pkg::cmd_t  cmd_i,
  input  kcu_pkg::in_t   item_i,
  output kcu_pkg::stat_t stat_o,
  output kcu_pkg::out_t  result_o
);

  localparam int unsigned SIDE  = MAX_SYMBOLS + 1;
  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(SIDE);
  localparam int unsigned TW    = RANK_BITS + 1;
  localparam int unsigned SW    = kcu_pkg::SYM_W;
  localparam int unsigned PW    = kcu_pkg::PAT_W;
  localparam logic [TW-1:0] SAT = {1'b1, {RANK_BITS{1'b0}}};

  // fill counters
  logic [AW-1:0] widx_q;
  logic [CW-1:0] col_q;

  // item registers
  logic [SW-1:0]        n_q, m_q;
  logic [SW:0]          len_q;
  logic [RANK_BITS-1:0] r_q;
  logic [PW-1:0]        mask_q, pat_q, pat_d;
  logic [AW-1:0]        base_q, raddr;
  logic [TW-1:0]        prev_q, rdata, wdata;
  logic [TW:0]          sum;
  kcu_pkg::out_t        res_q;

  logic dash, adv_dash;

  kcu_ram #(
    .WIDTH(TW),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.fill),
    .waddr_i(widx_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Pascal row i built from row i-1: rdata is entry (i-1,j), prev_q is (i-1,j-1)
  assign sum = {1'b0, prev_q} + {1'b0, rdata};
  always_comb begin
    if (widx_q < AW'(SIDE)) begin
      wdata = (col_q == '0) ? TW'(1) : '0;
    end else if (col_q == '0) begin
      wdata = TW'(1);
    end else if (sum > {1'b0, SAT}) begin
      wdata = SAT;
    end else begin
      wdata = sum[TW-1:0];
    end
  end

  assign dash     = {1'b0, r_q} < rdata;
  assign adv_dash = cmd_i.step ? dash : 1'b1;

  always_comb begin
    case (cmd_i.rd_sel)
      kcu_pkg::RD_FILL:  raddr = widx_q + AW'(1) - AW'(SIDE);
      kcu_pkg::RD_CHECK: raddr = AW'(len_q) * AW'(SIDE) + AW'(n_q);
      kcu_pkg::RD_NEXT:  raddr = base_q - AW'(SIDE) - AW'(adv_dash);
      default:           raddr = base_q;
    endcase
  end

  assign pat_d = (cmd_i.step && dash) ? (pat_q | mask_q) : pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
      col_q  <= '0;
    end else if (cmd_i.fill) begin
      widx_q <= widx_q + AW'(1);
      col_q  <= (col_q == CW'(SIDE - 1)) ? '0 : col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= rdata;
    base_q <= raddr;
    if (cmd_i.load) begin
      n_q    <= item_i.dash_count;
      m_q    <= item_i.dot_count;
      len_q  <= {1'b0, item_i.dash_count} + {1'b0, item_i.dot_count};
      r_q    <= RANK_BITS'(item_i.rank);
      mask_q <= PW'(1);
      pat_q  <= '0;
    end else if (cmd_i.step) begin
      pat_q  <= pat_d;
      mask_q <= mask_q << 1;
      if (dash) begin
        n_q <= n_q - SW'(1);
      end else begin
        r_q <= r_q - rdata[RANK_BITS-1:0];
        if (m_q != '0) begin
          m_q <= m_q - SW'(1);
        end
      end
    end
    if (cmd_i.fin_ok) begin
      res_q.pattern     <= pat_d;
      res_q.word_length <= len_q[SW-1:0];
      res_q.error       <= 1'b0;
    end else if (cmd_i.fin_err) begin
      res_q.pattern     <= '0;
      res_q.word_length <= '0;
      res_q.error       <= 1'b1;
    end
  end

  assign stat_o.fill_last = widx_q == AW'(DEPTH - 1);
  assign stat_o.too_long  = {1'b0, len_q} > (SW + 2)'(MAX_SYMBOLS);
  assign stat_o.rank_big  = !dash;
  assign stat_o.n_zero    = n_q == '0;
  assign stat_o.walk_last = dash && (n_q == SW'(1));

  assign result_o = res_q;

endmodule

FILE: sv/kth_combination_unrank.sv
// Top level: lexicographic unranking of dash/dot words, controller plus datapath.
`timescale 1ns / 1ps

// Returns the word at a zero-based rank among all words with the given dash
// and dot counts, dash sorting before dot. After reset busy_o stays high
// while the saturated binomial table is written into RAM, one entry a cycle.
// An item is taken when start_i is high and busy_o low. The block then checks
// the length while it reads the table entry for the rank check, then checks
// the rank, then walks the word up to its last dash; a length error ends the
// item in the check-read state and a rank error in the check state. The walk
// does one table read and one compare per symbol up to the last dash through
// the single RAM read port. The result word appears on result_o with done_o
// and is held until the next result, and busy_o is low in the cycle of
// done_o, so the next item may start there.
module kth_combination_unrank #(
  parameter int unsigned MAX_SYMBOLS = 64,
  parameter int unsigned RANK_BITS   = 30
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  kcu_pkg::in_t  item_i,
  output logic          busy_o,
  output logic          done_o,
  output kcu_pkg::out_t result_o
);

  kcu_pkg::cmd_t  cmd;
  kcu_pkg::stat_t stat;

  kcu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  kcu_dp #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .RANK_BITS  (RANK_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .item_i  (item_i),
    .stat_o  (stat),
    .result_o(result_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result word shown while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted word did not make the block busy");

  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.error) |-> (result_o.pattern == '0 && result_o.word_length == '0))
    else $error("error word carries a pattern");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

FILE: tb/sv/kth_combination_unrank_tb.sv
// Testbench: random and directed dash/dot unranking words checked against a local predictor.
`timescale 1ns / 1ps

module kth_combination_unrank_tb;

  localparam int unsigned MAX_SYM    = 64;
  localparam longint      SAT_COUNT  = 64'd1 << kcu_pkg::RANK_W;
  localparam int unsigned N_RANDOM   = 1200;
  localparam int unsigned CYCLE_CAP  = 1_000_000;
  localparam int unsigned DRAIN_WAIT = 100;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  kcu_pkg::in_t  item_i = '0;
  logic          busy_o;
  logic          done_o;
  kcu_pkg::out_t result_o;

  // C(i,j) clipped at 2^RANK_W, zero above the diagonal
  longint pascal_sat [0:MAX_SYM][0:MAX_SYM];

  kcu_pkg::in_t  pending_words [$];
  kcu_pkg::out_t expected_words [$];
  int unsigned issued_cnt = 0;
  int unsigned taken_cnt  = 0;
  int unsigned fail_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  kth_combination_unrank dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void build_pascal();
    for (int i = 0; i <= MAX_SYM; i++) begin
      for (int j = 0; j <= MAX_SYM; j++) begin
        if (j > i) begin
          pascal_sat[i][j] = 0;
        end else if (j == 0 || j == i) begin
          pascal_sat[i][j] = 1;
        end else begin
          pascal_sat[i][j] = pascal_sat[i-1][j-1] + pascal_sat[i-1][j];
          if (pascal_sat[i][j] > SAT_COUNT) pascal_sat[i][j] = SAT_COUNT;
        end
      end
    end
  endfunction

  function automatic kcu_pkg::out_t unrank_word(kcu_pkg::in_t it);
    kcu_pkg::out_t res;
    int     n_left;
    int     m_left;
    int     len;
    int     pos;
    longint r_left;
    longint c;
    res    = '0;
    n_left = it.dash_count;
    m_left = it.dot_count;
    len    = n_left + m_left;
    r_left = it.rank;
    pos    = 0;
    if (len > MAX_SYM) begin
      res.error = 1'b1;
      return res;
    end
    if (r_left >= pascal_sat[len][n_left]) begin
      res.error = 1'b1;
      return res;
    end
    while (n_left > 0) begin
      c = pascal_sat[n_left + m_left - 1][n_left - 1];
      if (r_left < c) begin
        if (pos < kcu_pkg::PAT_W) res.pattern[pos] = 1'b1;
        n_left--;
      end else begin
        r_left -= c;
        if (m_left > 0) m_left--;
      end
      pos++;
    end
    res.word_length = len[kcu_pkg::SYM_W-1:0];
    return res;
  endfunction

  function automatic kcu_pkg::in_t make_item(int d, int o, longint r);
    kcu_pkg::in_t it;
    it.dash_count = d[kcu_pkg::SYM_W-1:0];
    it.dot_count  = o[kcu_pkg::SYM_W-1:0];
    it.rank       = r[kcu_pkg::RANK_W-1:0];
    return it;
  endfunction

  function automatic kcu_pkg::in_t random_item();
    int     sel;
    int     band;
    int     len;
    int     d;
    longint cnt;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      return make_item($urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, SAT_COUNT - 1));
    end
    if (sel < 15) begin
      // too long
      d = $urandom_range(0, 127);
      return make_item(d, $urandom_range((d > MAX_SYM) ? 0 : MAX_SYM + 1 - d, 127),
                       $urandom_range(0, SAT_COUNT - 1));
    end
    band = $urandom_range(0, 19);
    if (band < 10) begin
      len = $urandom_range(0, 12);
    end else if (band < 17) begin
      len = $urandom_range(13, MAX_SYM - 1);
    end else begin
      len = MAX_SYM;
    end
    d   = $urandom_range(0, len);
    cnt = pascal_sat[len][d];
    if (sel < 30 && cnt < SAT_COUNT) begin
      return make_item(d, len - d, $urandom_range(cnt, SAT_COUNT - 1));
    end
    case ($urandom_range(0, 9))
      0:       return make_item(d, len - d, 0);
      1:       return make_item(d, len - d, cnt - 1);
      default: return make_item(d, len - d, $urandom_range(0, cnt - 1));
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // driver: new word only once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || taken_cnt == issued_cnt)) begin
      if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left--;
      end else if (pending_words.size() != 0) begin
        item_i  <= pending_words.pop_front();
        start_i <= 1'b1;
        issued_cnt++;
        gap_left = pick_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: record accepted words, check results
  always @(posedge clk_i) begin
    kcu_pkg::out_t exp_res;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_words.push_back(unrank_word(item_i));
        taken_cnt++;
      end
      if (done_o) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: %h", result_o);
          fail_cnt++;
        end else begin
          exp_res = expected_words.pop_front();
          if (result_o.pattern !== exp_res.pattern) begin
            $error("pattern: expected %h, got %h", exp_res.pattern, result_o.pattern);
            fail_cnt++;
          end
          if (result_o.word_length !== exp_res.word_length) begin
            $error("word_length: expected %0d, got %0d",
                   exp_res.word_length, result_o.word_length);
            fail_cnt++;
          end
          if (result_o.error !== exp_res.error) begin
            $error("error: expected %b, got %b", exp_res.error, result_o.error);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    build_pascal();

    // directed corners
    pending_words.push_back(make_item(0, 0, 0));
    pending_words.push_back(make_item(0, 0, 1));
    pending_words.push_back(make_item(1, 0, 0));
    pending_words.push_back(make_item(0, 1, 0));
    pending_words.push_back(make_item(1, 1, 1));
    pending_words.push_back(make_item(1, 1, 2));
    pending_words.push_back(make_item(5, 3, 55));
    pending_words.push_back(make_item(5, 3, 56));
    pending_words.push_back(make_item(64, 0, 0));
    pending_words.push_back(make_item(0, 64, 0));
    pending_words.push_back(make_item(32, 32, 0));
    pending_words.push_back(make_item(32, 32, SAT_COUNT - 1));
    pending_words.push_back(make_item(1, 63, 63));
    pending_words.push_back(make_item(1, 63, 64));
    pending_words.push_back(make_item(63, 1, 63));
    pending_words.push_back(make_item(2, 62, 2015));
    pending_words.push_back(make_item(20, 10, 30045014));
    pending_words.push_back(make_item(20, 10, 30045015));
    pending_words.push_back(make_item(30, 30, $urandom_range(0, SAT_COUNT - 1)));
    pending_words.push_back(make_item(65, 0, 0));
    pending_words.push_back(make_item(0, 65, 0));
    pending_words.push_back(make_item(33, 32, 0));
    pending_words.push_back(make_item(127, 127, SAT_COUNT - 1));
    pending_words.push_back(make_item(64, 1, 0));

    for (int k = 0; k < N_RANDOM; k++) pending_words.push_back(random_item());

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_words.size() != 0 || start_i || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
